// ===== rtl/vipimux_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual IPI pending mux package
// Shared types, field widths, command and result codes, and register
// indexes for the virtual IPI pending multiplexer.
// ----------------------------------------------------------------------------
package vipimux_pkg;

  // Default sizes of the block.
  localparam int unsigned DEF_NUM_CPUS         = 8;
  localparam int unsigned DEF_NUM_VIRTUAL_IPIS = 16;

  // Fixed field widths of the input and result words.
  localparam int unsigned IPI_W    = 4;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CPU_W    = 3;
  localparam int unsigned PARENT_W = 10;
  localparam int unsigned COUNT_W  = 5;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_IPIS_IN_USE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_ENABLED = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARENT_LINE   = 2'd2;

  // Register reset values.
  localparam logic [COUNT_W-1:0]  IPIS_IN_USE_RST   = 5'd16;
  localparam logic                CLEAR_ENABLED_RST = 1'b1;
  localparam logic [PARENT_W-1:0] PARENT_LINE_RST   = 10'd0;

  // Input commands.
  localparam logic CMD_SEND    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_TRIGGER  = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_DISPATCH = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_TRIGGER,
    SEQ_CLEAR,
    SEQ_DISPATCH
  } seq_state_e;

  // Input word.
  typedef struct packed {
    logic              cmd;
    logic [IPI_W-1:0]  ipi_number;
    logic [MASK_W-1:0] cpu_mask;
    logic [CPU_W-1:0]  cpu_index;
  } in_word_t;

  // Result word.
  typedef struct packed {
    kind_e               kind;
    logic [MASK_W-1:0]   target_cpus;
    logic [PARENT_W-1:0] parent_id;
    logic [IPI_W-1:0]    dispatched_ipi;
    logic [CPU_W-1:0]    on_cpu;
    logic                last;
  } out_word_t;

endpackage

// ===== rtl/virtual_ipi_pending_mux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Virtual IPI pending multiplexer
// Keeps a pending bitmap per CPU, raises the parent interrupt on send and
// dispatches pending virtual IPIs in ascending order on process.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o | in_word_i (in_word_t)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (out_word_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A send word is accepted in the idle state and then emits one trigger result.
// A process word emits a clear if clearing is enabled and one result per
// dispatched IPI: the shared find-first-set unit yields one dispatch per cycle
// while the output is not stalled. With nothing to report, it emits none.
// Reset clears all bitmaps and loads the register defaults.
// A stalled output with a word waiting holds the sequencer in its state.

module virtual_ipi_pending_mux
  import vipimux_pkg::*;
#(
  parameter int unsigned NUM_CPUS         = DEF_NUM_CPUS,
  parameter int unsigned NUM_VIRTUAL_IPIS = DEF_NUM_VIRTUAL_IPIS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_word_t               in_word_i,
  // Output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_word_t              out_word_o,
  // Configuration channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Only CPUs that the mask and index fields can reach are stored, and only
  // IPI numbers that the IPI field can name.
  localparam int unsigned STORED_CPUS = (NUM_CPUS < MASK_W) ? NUM_CPUS : MASK_W;
  localparam int unsigned STORED_IPIS =
    (NUM_VIRTUAL_IPIS < (1 << IPI_W)) ? NUM_VIRTUAL_IPIS : (1 << IPI_W);

  typedef logic [STORED_IPIS-1:0] ipi_vec_t;

  // Configuration registers
  logic [COUNT_W-1:0]  ipis_in_use_q;
  logic                clear_enabled_q;
  logic [PARENT_W-1:0] parent_line_q;

  // Sequencer and working state
  seq_state_e state_q, state_d;
  in_word_t   item_q, item_d;
  ipi_vec_t   taken_q, taken_d;
  ipi_vec_t   pending_q [STORED_CPUS];
  ipi_vec_t   pending_d [STORED_CPUS];

  // Output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  // Helper signals
  logic       accept;
  logic       out_room;
  logic       emit;
  out_word_t  emit_word;
  ipi_vec_t   ipi_onehot;
  ipi_vec_t   count_mask;
  ipi_vec_t   row_sel;
  ipi_vec_t   ffs_onehot;
  ipi_vec_t   ffs_rest;
  logic [IPI_W-1:0] ffs_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != SEQ_IDLE);
  assign accept      = in_valid_i && (state_q == SEQ_IDLE);
  assign out_room    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipis_in_use_q   <= IPIS_IN_USE_RST;
      clear_enabled_q <= CLEAR_ENABLED_RST;
      parent_line_q   <= PARENT_LINE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IPIS_IN_USE:   ipis_in_use_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_CLEAR_ENABLED: clear_enabled_q <= cfg_data_i[0];
        CFG_PARENT_LINE:   parent_line_q   <= cfg_data_i[PARENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming word: IPI bit to set, bitmap row to read, and the
  // mask of IPIs that are dispatched at all.
  always_comb begin
    ipi_onehot = '0;
    count_mask = '0;
    row_sel    = '0;
    for (int b = 0; b < STORED_IPIS; b++) begin
      ipi_onehot[b] = (in_word_i.ipi_number == IPI_W'(b));
      count_mask[b] = (COUNT_W'(b) < ipis_in_use_q);
    end
    for (int c = 0; c < STORED_CPUS; c++) begin
      if (in_word_i.cpu_index == CPU_W'(c)) begin
        row_sel = pending_q[c];
      end
    end
  end

  // Shared find-first-set unit over the bits still to dispatch.
  always_comb begin
    ffs_idx    = '0;
    ffs_onehot = '0;
    for (int b = STORED_IPIS - 1; b >= 0; b--) begin
      if (taken_q[b]) begin
        ffs_idx    = IPI_W'(b);
        ffs_onehot = '0;
        ffs_onehot[b] = 1'b1;
      end
    end
    ffs_rest = taken_q & ~ffs_onehot;
  end

  // Sequencer: next state, bitmap updates and the result to emit.
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    taken_d   = taken_q;
    pending_d = pending_q;
    emit      = 1'b0;
    emit_word = '0;
    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          item_d = in_word_i;
          if (in_word_i.cmd == CMD_SEND) begin
            for (int c = 0; c < STORED_CPUS; c++) begin
              if (in_word_i.cpu_mask[c]) begin
                pending_d[c] = pending_q[c] | ipi_onehot;
              end
            end
            state_d = SEQ_TRIGGER;
          end else begin
            for (int c = 0; c < STORED_CPUS; c++) begin
              if (in_word_i.cpu_index == CPU_W'(c)) begin
                pending_d[c] = '0;
              end
            end
            taken_d = row_sel & count_mask;
            if (clear_enabled_q) begin
              state_d = SEQ_CLEAR;
            end else if (taken_d != '0) begin
              state_d = SEQ_DISPATCH;
            end else begin
              state_d = SEQ_IDLE;
            end
          end
        end
      end
      SEQ_TRIGGER: begin
        if (out_room) begin
          emit                  = 1'b1;
          emit_word.kind        = KIND_TRIGGER;
          emit_word.target_cpus = item_q.cpu_mask;
          emit_word.parent_id   = parent_line_q;
          emit_word.last        = 1'b1;
          state_d               = SEQ_IDLE;
        end
      end
      SEQ_CLEAR: begin
        if (out_room) begin
          emit                = 1'b1;
          emit_word.kind      = KIND_CLEAR;
          emit_word.parent_id = parent_line_q;
          emit_word.on_cpu    = item_q.cpu_index;
          emit_word.last      = (taken_q == '0);
          state_d             = (taken_q == '0) ? SEQ_IDLE : SEQ_DISPATCH;
        end
      end
      SEQ_DISPATCH: begin
        if (out_room) begin
          emit                     = 1'b1;
          emit_word.kind           = KIND_DISPATCH;
          emit_word.dispatched_ipi = ffs_idx;
          emit_word.on_cpu         = item_q.cpu_index;
          emit_word.last           = (ffs_rest == '0);
          taken_d                  = ffs_rest;
          if (ffs_rest == '0) begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Output register: loads a new word when it is empty or being taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_word_d  = emit_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and bitmaps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < STORED_CPUS; c++) begin
        pending_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      pending_q   <= pending_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_word_q <= out_word_d;
  end

  // The dispatch state is only entered with bits left to dispatch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_DISPATCH |-> taken_q != '0)
    else $error("dispatch state entered with no pending bits");

  // A dispatched IPI always lies below the configured count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_DISPATCH
      |-> {1'b0, out_word_o.dispatched_ipi} < ipis_in_use_q)
    else $error("dispatched IPI at or above the configured count");

  // The last result of a word returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_word.last |=> state_q == SEQ_IDLE)
    else $error("sequencer busy after the last result");

  // A trigger ends its word and concerns no single CPU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_TRIGGER
      |-> out_word_o.last && out_word_o.on_cpu == '0)
    else $error("malformed trigger result");

endmodule
